// ----- src/window_mode_filter_assert.svh -----
// Assertion shorthands for the mode filter; clocked on clk, held off during reset.
`ifndef WINDOW_MODE_FILTER_ASSERT_SVH
`define WINDOW_MODE_FILTER_ASSERT_SVH

// same-cycle implication
`define WMF_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define WMF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/wmf_pkg.sv -----
`default_nettype none

package wmf_pkg;

    localparam int WINDOW          = 10;
    localparam int SAMPLE_BITS     = 16;
    localparam int SLOT_W          = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W           = $clog2(WINDOW + 1);
    localparam int VALUE_W         = 16;
    localparam int COUNT_FIELD_W   = 4;
    localparam int COUNT_FIELD_MAX = 15;
    localparam int OUT_DATA_W      = ((VALUE_W + COUNT_FIELD_W + 7) / 8) * 8;

    typedef logic [SAMPLE_BITS-1:0] sample_t;
    typedef logic [CNT_W-1:0]       count_t;
    typedef logic [SLOT_W-1:0]      slot_t;

    localparam slot_t LAST_SLOT = slot_t'(WINDOW - 1);

    typedef struct packed {
        logic load;
        logic count_en;
    } cell_ctrl_t;

    typedef struct packed {
        sample_t value;
        count_t  count;
    } best_t;

endpackage

`default_nettype wire

// ----- src/wmf_cell.sv -----
`default_nettype none

// One window slot: holds its sample, counts matches as the stored samples
// rotate past, then takes part in the ripple that picks the winner.
module wmf_cell (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire wmf_pkg::cell_ctrl_t ctrl,
    input  wire logic                write_hit,
    input  wire wmf_pkg::sample_t    sample,
    input  wire wmf_pkg::sample_t    trav_in,
    output wmf_pkg::sample_t         trav_out,
    input  wire wmf_pkg::best_t      best_in,
    output wmf_pkg::best_t           best_out
);

    wmf_pkg::sample_t value_reg;
    wmf_pkg::sample_t trav_reg;
    wmf_pkg::count_t  cnt_reg;
    wmf_pkg::best_t   best_reg;
    wmf_pkg::best_t   best_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= '0;
        end
        else if (ctrl.load && write_hit)
        begin
            value_reg <= sample;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            // the freshly written word starts its own lap
            trav_reg <= write_hit ? sample : value_reg;
            cnt_reg  <= '0;
        end
        else if (ctrl.count_en)
        begin
            trav_reg <= trav_in;
            if (value_reg == trav_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // strict compare: an equal count further up the chain loses to the lower slot
    always_comb
    begin
        if (cnt_reg > best_in.count)
        begin
            best_next.value = value_reg;
            best_next.count = cnt_reg;
        end
        else
        begin
            best_next = best_in;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg <= best_next;
    end

    assign trav_out = trav_reg;
    assign best_out = best_reg;

endmodule

`default_nettype wire

// ----- src/window_mode_filter.sv -----
`default_nettype none

// Sliding-window mode filter. Each 16-bit sample on the slave stream overwrites
// the oldest of WINDOW slots (all zero after reset); one word then leaves on the
// master stream with the most frequent value in the window and how many slots
// hold it, the lowest slot winning a tie, the count saturating at 15. The edge
// that accepts a sample writes it into its slot; in S_COUNT the stored samples
// then rotate once round the chain of slot cells so each cell counts its
// matches, in S_SCAN the best count ripples down the chain, and S_OUT registers
// the result. A new sample is taken only in S_IDLE, so not before that.
// The next sample is taken as soon as the result is registered, even while that
// result still waits on m_tready; a result that finds the previous one still
// waiting holds the block until m_tready takes it.
module window_mode_filter (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [15:0]                     s_tdata,  // [15:0] sample
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [wmf_pkg::OUT_DATA_W-1:0]       m_tdata   // [15:0] mode_value,
                                                           // [19:16] mode_count
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_COUNT,
        S_SCAN,
        S_OUT
    } state_t;

    state_t                          state_reg;
    wmf_pkg::slot_t                  phase_reg;
    wmf_pkg::slot_t                  write_slot_reg;
    logic                            m_tvalid_reg;
    logic [wmf_pkg::OUT_DATA_W-1:0]  m_tdata_reg;

    wmf_pkg::cell_ctrl_t             ctrl;
    wmf_pkg::sample_t                sample;
    wmf_pkg::sample_t                trav_w [wmf_pkg::WINDOW];
    wmf_pkg::best_t                  best_w [wmf_pkg::WINDOW];
    wmf_pkg::best_t                  best_none;
    wmf_pkg::best_t                  winner;
    logic [wmf_pkg::COUNT_FIELD_W-1:0] count_sat;
    logic                            accept;
    logic                            out_free;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign sample   = wmf_pkg::sample_t'(s_tdata);

    assign ctrl.load     = accept;
    assign ctrl.count_en = (state_reg == S_COUNT);

    assign best_none = '0;

    for (genvar k = 0; k < wmf_pkg::WINDOW; k++)
    begin : g_cell
        wmf_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .write_hit (write_slot_reg == wmf_pkg::slot_t'(k)),
            .sample    (sample),
            .trav_in   (trav_w[(k + wmf_pkg::WINDOW - 1) % wmf_pkg::WINDOW]),
            .trav_out  (trav_w[k]),
            .best_in   ((k == 0) ? best_none : best_w[(k == 0) ? 0 : k - 1]),
            .best_out  (best_w[k])
        );
    end

    assign winner = best_w[wmf_pkg::WINDOW - 1];

    always_comb
    begin
        if (int'(winner.count) > wmf_pkg::COUNT_FIELD_MAX)
        begin
            count_sat = wmf_pkg::COUNT_FIELD_W'(wmf_pkg::COUNT_FIELD_MAX);
        end
        else
        begin
            count_sat = wmf_pkg::COUNT_FIELD_W'(winner.count);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            phase_reg      <= '0;
            write_slot_reg <= '0;
            m_tvalid_reg   <= 1'b0;
            m_tdata_reg    <= '0;
        end
        else
        begin
            // in S_OUT a taken word is replaced by the new one below
            if (m_tvalid_reg && m_tready && state_reg != S_OUT)
            begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg      <= S_COUNT;
                        phase_reg      <= '0;
                        write_slot_reg <= (write_slot_reg == wmf_pkg::LAST_SLOT)
                                          ? '0 : write_slot_reg + 1'b1;
                    end
                end
                S_COUNT:
                begin
                    if (phase_reg == wmf_pkg::LAST_SLOT)
                    begin
                        state_reg <= S_SCAN;
                        phase_reg <= '0;
                    end
                    else
                    begin
                        phase_reg <= phase_reg + 1'b1;
                    end
                end
                S_SCAN:
                begin
                    if (phase_reg == wmf_pkg::LAST_SLOT)
                    begin
                        state_reg <= S_OUT;
                        phase_reg <= '0;
                    end
                    else
                    begin
                        phase_reg <= phase_reg + 1'b1;
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= wmf_pkg::OUT_DATA_W'({count_sat,
                                        wmf_pkg::VALUE_W'(winner.value)});
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`include "window_mode_filter_assert.svh"

    `WMF_ASSERT_NEXT(a_accept_starts_count, accept,
        state_reg == S_COUNT && phase_reg == '0,
        "accepted word did not start the count lap")
    `WMF_ASSERT_NEXT(a_slot_advance, accept,
        write_slot_reg == (($past(write_slot_reg) == wmf_pkg::LAST_SLOT)
                           ? '0 : $past(write_slot_reg) + 1'b1),
        "write slot did not advance")
    `WMF_ASSERT(a_slot_range, 1'b1, write_slot_reg <= wmf_pkg::LAST_SLOT,
        "write slot beyond window")
    `WMF_ASSERT(a_count_nonzero, m_tvalid_reg,
        m_tdata_reg[wmf_pkg::VALUE_W +: wmf_pkg::COUNT_FIELD_W] != '0,
        "result word with zero count")

endmodule

`default_nettype wire
